>>> hdl/paired_resource_waiter_arbiter_unit_assert.svh
// Assertion macros for the paired resource waiter arbiter.
// Included by the top level; depends on a clock named clk and reset rst_n.
`ifndef PAIRED_RESOURCE_WAITER_ARBITER_UNIT_ASSERT_SVH
`define PAIRED_RESOURCE_WAITER_ARBITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PRWA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prwa: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PRWA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prwa: next-cycle check failed");

`endif

>>> hdl/prwa_pkg.sv
// Shared types and constants for the paired resource waiter arbiter.
// No dependencies.
`timescale 1ns / 1ps

package prwa_pkg;

  localparam int unsigned ID_W  = 5;
  localparam int unsigned CNT_W8 = 8;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic REG_USER_COUNT    = 1'b0;
  localparam logic REG_USES_REQUIRED = 1'b1;

  localparam logic [ID_W-1:0]   USER_COUNT_RST    = 5'd16;
  localparam logic [CNT_W8-1:0] USES_REQUIRED_RST = 8'd1;
  localparam logic [CNT_W8-1:0] USE_COUNT_MAX     = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_EMIT0,
    ST_EMIT1
  } prwa_state_t;

  typedef struct packed {
    logic            granted;
    logic [ID_W-1:0] grantee;
    logic            bad_id;
    logic            all_done;
    logic            last;
  } prwa_res_t;

endpackage

>>> hdl/prwa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module prwa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/prwa_out_reg.sv
// Result output register: holds one result until the consumer takes it.
// Depends on prwa_pkg.
`timescale 1ns / 1ps

module prwa_out_reg
  import prwa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_valid,
  input  prwa_res_t           load_res,
  output logic                load_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_granted,
  output logic [ID_W-1:0]     out_grantee,
  output logic                out_bad_id,
  output logic                out_all_done,
  output logic                out_last
);

  logic      valid_r;
  logic      valid_nxt;
  prwa_res_t res_r;

  // Take a new result when empty or when the held one leaves this cycle.
  assign load_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_valid && load_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      res_r <= load_res;
    end
  end

  assign out_valid    = valid_r;
  assign out_granted  = res_r.granted;
  assign out_grantee  = res_r.grantee;
  assign out_bad_id   = res_r.bad_id;
  assign out_all_done = res_r.all_done;
  assign out_last     = res_r.last;

endmodule

>>> hdl/paired_resource_waiter_arbiter_unit.sv
// Paired resource waiter arbiter (waiter scheme for a ring of users and resources).
// Users 1..n share n resources in a ring; user k needs resource k-1 and resource k mod n.
// A request is granted at once when both are free, otherwise the user joins an ordered
// wait queue (dropped when the queue is full). A release frees both resources, counts
// one completed use, then walks the queue from its head and grants and removes up to
// two waiters whose pairs are free; entries above the current ring size are dropped.
// Each result carries all_done, high once every user has reached uses_required.
// Timing: one item at a time. A request or bad id passes through the DECODE and EMIT0
// states to the output register; a release with waiters also walks the wait queue in the
// SCAN state before EMIT0, one entry per cycle through the queue RAM's single read port.
// A second grant adds the EMIT1 state. The input reopens the cycle after the last result
// is loaded. The output register lets the next item transfer while a result is still
// waiting to be taken. No clearing pass is needed after reset: use counts carry per-entry
// valid bits, and the queue is only read below its fill count.
// Depends on prwa_pkg, prwa_ram, prwa_out_reg and the assert header.
`timescale 1ns / 1ps

module paired_resource_waiter_arbiter_unit
  import prwa_pkg::*;
#(
  parameter int unsigned MAX_USERS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  // input channel
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_cmd,
  input  logic [4:0]      in_user_id,
  // result channel
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_granted,
  output logic [4:0]      out_grantee,
  output logic            out_bad_id,
  output logic            out_all_done,
  output logic            out_last,
  // configuration port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int unsigned IDX_W = $clog2(MAX_USERS);
  localparam int unsigned CNT_W = $clog2(MAX_USERS + 1);
  // Width that holds any id and any ring size up to MAX_USERS.
  localparam int unsigned RW    = (IDX_W >= ID_W) ? IDX_W + 1 : ID_W + 1;

  // ---------------------------------------------------------------------------
  // Index helpers
  // ---------------------------------------------------------------------------
  function automatic logic [RW-1:0] widen(input logic [ID_W-1:0] v);
    widen = {{(RW - ID_W){1'b0}}, v};
  endfunction

  // Left resource of a user: id - 1.
  function automatic logic [IDX_W-1:0] lo_idx(input logic [ID_W-1:0] id);
    logic [RW-1:0] t;
    t = widen(id) - RW'(1);
    lo_idx = t[IDX_W-1:0];
  endfunction

  // Right resource of a user: id mod n, with 1 <= id <= n.
  function automatic logic [IDX_W-1:0] hi_idx(input logic [ID_W-1:0] id,
                                               input logic [RW-1:0]   n);
    logic [RW-1:0] t;
    t = (widen(id) == n) ? '0 : widen(id);
    hi_idx = t[IDX_W-1:0];
  endfunction

  function automatic logic id_ok(input logic [ID_W-1:0] id, input logic [RW-1:0] n);
    id_ok = (id != '0) && (widen(id) <= n);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]   user_count_r;
  logic [CNT_W8-1:0] uses_required_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_count_r    <= USER_COUNT_RST;
      uses_required_r <= USES_REQUIRED_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_USER_COUNT:    user_count_r    <= pwdata[ID_W-1:0];
        REG_USES_REQUIRED: uses_required_r <= pwdata[CNT_W8-1:0];
        default:           user_count_r    <= user_count_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_USER_COUNT:    prdata = {{(32 - ID_W){1'b0}}, user_count_r};
      REG_USES_REQUIRED: prdata = {{(32 - CNT_W8){1'b0}}, uses_required_r};
      default:           prdata = '0;
    endcase
  end

  // Ring size, saturated to 2..MAX_USERS.
  logic [RW-1:0] uc_w;
  logic [RW-1:0] ring_n;

  assign uc_w   = widen(user_count_r);
  assign ring_n = (uc_w < RW'(2))         ? RW'(2) :
                  (uc_w > RW'(MAX_USERS)) ? RW'(MAX_USERS) : uc_w;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  prwa_state_t          state_r, state_nxt;
  logic [MAX_USERS-1:0] free_r, free_nxt;         // resource free flags
  logic [MAX_USERS-1:0] fin_r, fin_nxt;           // user finished flags
  logic [MAX_USERS-1:0] cnt_vld_r, cnt_vld_nxt;   // use count entry written
  logic [CNT_W-1:0]     wait_count_r, wait_count_nxt;
  logic [CNT_W-1:0]     proc_r, proc_nxt;         // queue entry under inspection
  logic [CNT_W-1:0]     keep_r, keep_nxt;         // compaction write pointer
  logic [1:0]           grants_r, grants_nxt;
  logic [ID_W-1:0]      who0_r, who0_nxt;
  logic [ID_W-1:0]      who1_r, who1_nxt;
  logic                 cmd_r;
  logic [ID_W-1:0]      id_r;
  prwa_res_t            res0_r, res0_nxt;
  prwa_res_t            res1_r, res1_nxt;

  // ---------------------------------------------------------------------------
  // Memories: wait queue and per-user use counts
  // ---------------------------------------------------------------------------
  logic              q_we;
  logic [IDX_W-1:0]  q_waddr;
  logic [ID_W-1:0]   q_wdata;
  logic [IDX_W-1:0]  q_raddr;
  logic [ID_W-1:0]   q_rdata;

  logic              u_we;
  logic [IDX_W-1:0]  u_waddr;
  logic [CNT_W8-1:0] u_wdata;
  logic [IDX_W-1:0]  u_raddr;
  logic [CNT_W8-1:0] u_rdata;

  prwa_ram #(.WIDTH(ID_W), .DEPTH(MAX_USERS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  prwa_ram #(.WIDTH(CNT_W8), .DEPTH(MAX_USERS)) u_count_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic      load_valid;
  logic      load_ready;
  prwa_res_t load_res;

  prwa_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (load_valid),
    .load_res     (load_res),
    .load_ready   (load_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_granted  (out_granted),
    .out_grantee  (out_grantee),
    .out_bad_id   (out_bad_id),
    .out_all_done (out_all_done),
    .out_last     (out_last)
  );

  // ---------------------------------------------------------------------------
  // Combinational views
  // ---------------------------------------------------------------------------
  logic all_fin;

  // Every user below the ring size must be finished.
  always_comb begin
    all_fin = 1'b1;
    for (int i = 0; i < MAX_USERS; i++) begin
      if (RW'(i) < ring_n && !fin_r[i]) begin
        all_fin = 1'b0;
      end
    end
  end

  logic              in_xfer;
  logic [IDX_W-1:0]  id_lo, id_hi;
  logic [IDX_W-1:0]  e_lo, e_hi;
  logic [CNT_W8-1:0] cur_cnt, new_cnt, need_cnt;
  logic [CNT_W-1:0]  proc_inc;
  logic [CNT_W-1:0]  keep_inc;
  logic [CNT_W-1:0]  wait_inc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign id_lo    = lo_idx(id_r);
  assign id_hi    = hi_idx(id_r, ring_n);
  assign e_lo     = lo_idx(q_rdata);
  assign e_hi     = hi_idx(q_rdata, ring_n);

  assign cur_cnt  = cnt_vld_r[id_lo] ? u_rdata : '0;
  assign new_cnt  = (cur_cnt == USE_COUNT_MAX) ? cur_cnt : cur_cnt + CNT_W8'(1);
  assign need_cnt = (uses_required_r == '0) ? CNT_W8'(1) : uses_required_r;

  assign proc_inc = proc_r + CNT_W'(1);
  assign keep_inc = keep_r + CNT_W'(1);
  assign wait_inc = wait_count_r + CNT_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer: decode, queue walk, result emission
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    free_nxt       = free_r;
    fin_nxt        = fin_r;
    cnt_vld_nxt    = cnt_vld_r;
    wait_count_nxt = wait_count_r;
    proc_nxt       = proc_r;
    keep_nxt       = keep_r;
    grants_nxt     = grants_r;
    who0_nxt       = who0_r;
    who1_nxt       = who1_r;
    res0_nxt       = res0_r;
    res1_nxt       = res1_r;

    q_we     = 1'b0;
    q_waddr  = wait_count_r[IDX_W-1:0];
    q_wdata  = id_r;
    q_raddr  = '0;
    u_we     = 1'b0;
    u_waddr  = id_lo;
    u_wdata  = new_cnt;
    u_raddr  = lo_idx(in_user_id);

    load_valid = 1'b0;
    load_res   = res0_r;
    load_res.all_done = all_fin;

    case (state_r)
      ST_IDLE: begin
        // Count RAM read for the arriving user is already addressed.
        if (in_xfer) begin
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res0_nxt = '{granted: 1'b0, grantee: '0, bad_id: 1'b0, all_done: 1'b0,
                     last: 1'b1};
        state_nxt = ST_EMIT0;
        if (!id_ok(id_r, ring_n)) begin
          res0_nxt.bad_id = 1'b1;
        end else if (cmd_r == CMD_REQUEST) begin
          if (free_r[id_lo] && free_r[id_hi]) begin
            free_nxt[id_lo]  = 1'b0;
            free_nxt[id_hi]  = 1'b0;
            res0_nxt.granted = 1'b1;
            res0_nxt.grantee = id_r;
          end else if (wait_count_r < CNT_W'(MAX_USERS)) begin
            // Append to the tail of the queue.
            q_we           = 1'b1;
            wait_count_nxt = wait_inc;
          end
        end else begin
          // Release: free the pair, count the use, then walk the queue.
          free_nxt[id_lo]    = 1'b1;
          free_nxt[id_hi]    = 1'b1;
          u_we               = 1'b1;
          cnt_vld_nxt[id_lo] = 1'b1;
          if (new_cnt >= need_cnt) begin
            fin_nxt[id_lo] = 1'b1;
          end
          proc_nxt   = '0;
          keep_nxt   = '0;
          grants_nxt = '0;
          q_raddr    = '0;
          if (wait_count_r != '0) begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // q_rdata holds queue entry proc_r; prefetch the next one.
        q_raddr = proc_inc[IDX_W-1:0];
        if (id_ok(q_rdata, ring_n)) begin
          if (grants_r != 2'd2 && free_r[e_lo] && free_r[e_hi]) begin
            free_nxt[e_lo] = 1'b0;
            free_nxt[e_hi] = 1'b0;
            grants_nxt     = grants_r + 2'd1;
            if (grants_r == 2'd0) begin
              who0_nxt = q_rdata;
            end else begin
              who1_nxt = q_rdata;
            end
          end else begin
            // Keep the waiter, compacting toward the head.
            q_we     = 1'b1;
            q_waddr  = keep_r[IDX_W-1:0];
            q_wdata  = q_rdata;
            keep_nxt = keep_inc;
          end
        end
        proc_nxt = proc_inc;
        if (proc_inc == wait_count_r) begin
          wait_count_nxt = keep_nxt;
          state_nxt      = ST_EMIT0;
          res0_nxt = '{granted: 1'b0, grantee: '0, bad_id: 1'b0, all_done: 1'b0,
                       last: 1'b1};
          res1_nxt = '{granted: 1'b1, grantee: who1_nxt, bad_id: 1'b0, all_done: 1'b0,
                       last: 1'b1};
          if (grants_nxt != 2'd0) begin
            res0_nxt.granted = 1'b1;
            res0_nxt.grantee = who0_nxt;
            res0_nxt.last    = (grants_nxt == 2'd1);
          end
        end
      end

      ST_EMIT0: begin
        load_valid = 1'b1;
        if (load_ready) begin
          state_nxt = res0_r.last ? ST_IDLE : ST_EMIT1;
        end
      end

      ST_EMIT1: begin
        load_valid = 1'b1;
        load_res   = res1_r;
        load_res.all_done = all_fin;
        if (load_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_r       <= '1;
      fin_r        <= '0;
      cnt_vld_r    <= '0;
      wait_count_r <= '0;
      grants_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      free_r       <= free_nxt;
      fin_r        <= fin_nxt;
      cnt_vld_r    <= cnt_vld_nxt;
      wait_count_r <= wait_count_nxt;
      grants_r     <= grants_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_cmd;
      id_r  <= in_user_id;
    end
    proc_r <= proc_nxt;
    keep_r <= keep_nxt;
    who0_r <= who0_nxt;
    who1_r <= who1_nxt;
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "paired_resource_waiter_arbiter_unit_assert.svh"

  // Queue fill never exceeds its depth.
  `PRWA_ASSERT_IMPL(a_queue_bound, 1'b1, wait_count_r <= CNT_W'(MAX_USERS))
  // Compaction pointer trails the walk pointer, so no unread entry is overwritten.
  `PRWA_ASSERT_IMPL(a_keep_trails, state_r == ST_SCAN, keep_r <= proc_r)
  // One item at a time: a transfer closes the input until its results are queued.
  `PRWA_ASSERT_NEXT(a_one_item, in_xfer, !in_ready)
  // A walk never grants more than two waiters.
  `PRWA_ASSERT_IMPL(a_grant_limit, state_r == ST_SCAN, grants_r <= 2'd2)

endmodule
